FILE: src/lztbp_pkg.sv
// shared widths, codes and command/status types for the lz token bit packer
package lztbp_pkg;

  // defaults for the top-level parameters
  localparam int ADDR_BITS_DEF    = 16;
  localparam int OFFSET_BITS1_DEF = 1;
  localparam int OFFSET_BITS2_DEF = 4;
  localparam int OFFSET_BITS4_DEF = 16;

  // field widths
  localparam int TYPE_W     = 3;
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 9;
  localparam int OFS_W      = 17;
  localparam int WADDR_W    = 16;
  localparam int LIM1_W     = 9;
  localparam int LIM2_W     = 13;
  localparam int LIM3_W     = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  // request kinds
  localparam logic [TYPE_W-1:0] REQ_RAW   = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_LIT   = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_RUN   = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_MATCH = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_END   = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIM1 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIM2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIM3 = 2'd2;

  // register reset values
  localparam logic [LIM1_W-1:0] LIM1_RST = 9'd2;
  localparam logic [LIM2_W-1:0] LIM2_RST = 13'd18;
  localparam logic [LIM3_W-1:0] LIM3_RST = 14'd274;

  // run header bias and escape sequence
  localparam int RUN_BIAS     = 27;
  localparam int ESCAPE_ZEROS = 16;
  localparam int ESC_FLAGS    = ESCAPE_ZEROS + 2;

  typedef struct packed {
    logic take;       // latch token and load head flag piece
    logic load_offs;  // load offset flag piece
    logic drain;      // push flag bits into the flag byte
    logic put_byte;   // write the data byte
    logic flush;      // write back the open flag byte
    logic end_tok;    // current token is the end mark
  } lztbp_cmd_t;

  typedef struct packed {
    logic out_free;    // output register can take a write
    logic drain_emit;  // this drain step fills the flag byte
    logic drain_done;  // this drain step empties the piece
    logic offs_byte;   // offset class carries a data byte
  } lztbp_sts_t;

endpackage

FILE: src/lz_token_bit_packer_top.sv
// top level of the lz token bit packer: stream ports, config port, sequencer and datapath
//
//  channel | dir | handshake              | contents
//  --------+-----+------------------------+-----------------------------------------
//  s_      | in  | s_tvalid / s_tready    | one token request (kind in s_tuser)
//  m_      | out | m_tvalid / m_tready    | one byte write with address, tlast on end
//  cfg_    | in  | cfg_valid / cfg_ready  | offset class limit write by index
//
//  steps: the sequencer takes a request, then drains each flag piece (head piece, then
//    offset piece for a match) one flag byte at a time, then writes a data byte or the
//    final flag byte if the token needs one
//  the drain fills at most one flag byte per cycle while the output register has room
//  reset: synchronous, clears the pointers, the open flag byte and the output register;
//    limits return to 2, 18 and 274
//  stalls: the output register holds one write; the sequencer waits only when it must
//    write while that register is full and not taken; a new request is taken while the
//    previous final write still waits
module lz_token_bit_packer_top #(
  parameter int ADDR_BITS    = lztbp_pkg::ADDR_BITS_DEF,
  parameter int OFFSET_BITS1 = lztbp_pkg::OFFSET_BITS1_DEF,
  parameter int OFFSET_BITS2 = lztbp_pkg::OFFSET_BITS2_DEF,
  parameter int OFFSET_BITS4 = lztbp_pkg::OFFSET_BITS4_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // request stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // byte_value [7:0], token_length [16:8], match_offset [33:17], zero [39:34]
  input  logic [lztbp_pkg::IN_DATA_W-1:0]  s_tdata,
  // req_type [2:0]
  input  logic [lztbp_pkg::TYPE_W-1:0]     s_tuser,
  // write stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // write_address [15:0], write_data [23:16]
  output logic [lztbp_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                             m_tlast,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lztbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lztbp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lztbp_pkg::*;

  lztbp_cmd_t          cmd;
  lztbp_sts_t          sts;
  logic [WADDR_W-1:0]  out_addr;
  logic [BYTE_W-1:0]   out_data;

  // limit registers take a write in any cycle
  assign cfg_ready = 1'b1;

  lztbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_type  (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  lztbp_datapath #(
    .ADDR_BITS    (ADDR_BITS),
    .OFFSET_BITS1 (OFFSET_BITS1),
    .OFFSET_BITS2 (OFFSET_BITS2),
    .OFFSET_BITS4 (OFFSET_BITS4)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_type   (s_tuser),
    .in_byte   (s_tdata[7:0]),
    .in_len    (s_tdata[16:8]),
    .in_off    (s_tdata[33:17]),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_addr  (out_addr),
    .out_data  (out_data),
    .out_last  (m_tlast)
  );

  // address in the low half, data byte above it
  assign m_tdata = {out_data, out_addr};

endmodule

FILE: src/lztbp_ctrl.sv
// token sequencer state machine for the lz token bit packer
module lztbp_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lztbp_pkg::TYPE_W-1:0] in_type,
  input  lztbp_pkg::lztbp_sts_t        sts,
  output lztbp_pkg::lztbp_cmd_t        cmd
);
  import lztbp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_HEAD  = 5'b00010,
    S_OFFS  = 5'b00100,
    S_BYTE  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t              state, state_next;
  logic [TYPE_W-1:0]   kind;
  logic                accept;
  logic                advance;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  // a drain that fills the flag byte needs room in the output register
  assign advance  = !sts.drain_emit || sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= REQ_RAW;
    end else begin
      state <= state_next;
      if (accept) begin
        kind <= in_type;
      end
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.end_tok = (kind == REQ_END);
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.take = 1'b1;
          if (in_type == REQ_RAW) begin
            state_next = S_BYTE;
          end else if (in_type == REQ_LIT || in_type == REQ_RUN ||
                       in_type == REQ_MATCH || in_type == REQ_END) begin
            state_next = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        if (advance) begin
          cmd.drain = 1'b1;
          if (sts.drain_done) begin
            priority if (kind == REQ_MATCH) begin
              cmd.load_offs = 1'b1;
              state_next    = S_OFFS;
            end else if (kind == REQ_END) begin
              state_next = sts.drain_emit ? S_IDLE : S_FLUSH;
            end else begin
              state_next = S_BYTE;
            end
          end
        end
      end
      S_OFFS: begin
        if (advance) begin
          cmd.drain = 1'b1;
          if (sts.drain_done) begin
            state_next = sts.offs_byte ? S_BYTE : S_IDLE;
          end
        end
      end
      S_BYTE: begin
        if (sts.out_free) begin
          cmd.put_byte = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_drain_state: assert property (@(posedge clk) disable iff (rst)
    cmd.drain |-> (state == S_HEAD || state == S_OFFS))
    else $error("drain issued outside a flag piece");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_type == REQ_RAW || in_type == REQ_LIT || in_type == REQ_RUN ||
                in_type == REQ_MATCH || in_type == REQ_END)) |=> !in_ready)
    else $error("token accepted but sequencer went idle");

endmodule

FILE: src/lztbp_datapath.sv
// flag packing, pointer and output register datapath for the lz token bit packer
module lztbp_datapath #(
  parameter int ADDR_BITS    = lztbp_pkg::ADDR_BITS_DEF,
  parameter int OFFSET_BITS1 = lztbp_pkg::OFFSET_BITS1_DEF,
  parameter int OFFSET_BITS2 = lztbp_pkg::OFFSET_BITS2_DEF,
  parameter int OFFSET_BITS4 = lztbp_pkg::OFFSET_BITS4_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [lztbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lztbp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [lztbp_pkg::TYPE_W-1:0]     in_type,
  input  logic [lztbp_pkg::BYTE_W-1:0]     in_byte,
  input  logic [lztbp_pkg::LEN_W-1:0]      in_len,
  input  logic [lztbp_pkg::OFS_W-1:0]      in_off,
  input  lztbp_pkg::lztbp_cmd_t            cmd,
  output lztbp_pkg::lztbp_sts_t            sts,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lztbp_pkg::WADDR_W-1:0]    out_addr,
  output logic [lztbp_pkg::BYTE_W-1:0]     out_data,
  output logic                             out_last
);
  import lztbp_pkg::*;

  localparam int HI_W    = OFFSET_BITS4 - 8;
  localparam int FLD_A   = (OFFSET_BITS1 > OFFSET_BITS2) ? OFFSET_BITS1 : OFFSET_BITS2;
  localparam int FLD_MAX = (FLD_A > HI_W) ? FLD_A : HI_W;
  localparam int OFW     = FLD_MAX + 1;
  localparam int SEG_W   = (2 * LEN_W > OFW + 2) ? 2 * LEN_W : OFW + 2;
  localparam int CNT_W   = $clog2(SEG_W + 1);
  localparam int AXW     = (ADDR_BITS > WADDR_W) ? ADDR_BITS : WADDR_W;

  // configuration
  logic [LIM1_W-1:0]    lim1;
  logic [LIM2_W-1:0]    lim2;
  logic [LIM3_W-1:0]    lim3;

  // stream state
  logic [ADDR_BITS-1:0] wp;
  logic [ADDR_BITS-1:0] faddr;
  logic [BYTE_W-1:0]    fbyte;
  logic [2:0]           fill;
  logic                 fopen;

  // flag piece being drained, left aligned
  logic [SEG_W-1:0]     seg;
  logic [CNT_W-1:0]     cnt;

  // token registers
  logic [LEN_W-1:0]     len_q;
  logic [OFS_W-1:0]     v0;
  logic [BYTE_W-1:0]    dbyte;

  // head piece
  logic [3:0]           nbits;
  logic [LEN_W-1:0]     head_val;
  logic [CNT_W-1:0]     head_cnt;
  logic [SEG_W-1:0]     head_seg;
  logic [LEN_W-1:0]     run_raw;

  // offset piece
  logic                 cls1, cls2, cls3;
  logic [OFS_W-1:0]     lim_sel;
  logic [OFS_W-1:0]     sub;
  logic [1:0]           zeros;
  logic [OFW-1:0]       offs_val;
  logic [CNT_W-1:0]     offs_cnt;
  logic [SEG_W-1:0]     offs_seg;

  // drain step
  logic [3:0]           room;
  logic [3:0]           k;
  logic [3:0]           fsum;
  logic [BYTE_W-1:0]    top;
  logic [BYTE_W-1:0]    ins;
  logic [BYTE_W-1:0]    fnew;
  logic [ADDR_BITS-1:0] faddr_eff;

  // output mux
  logic                 emit;
  logic [ADDR_BITS-1:0] addr_sel;
  logic [AXW-1:0]       addr_ext;
  logic [BYTE_W-1:0]    data_sel;
  logic                 last_sel;

  // gamma length: bit length of the match length, at least one
  always_comb begin
    nbits = 4'd1;
    for (int i = 1; i < LEN_W; i++) begin
      if (in_len[i]) begin
        nbits = 4'(i + 1);
      end
    end
  end

  assign run_raw = in_len - LEN_W'(RUN_BIAS);

  always_comb begin
    head_val = '0;
    head_cnt = '0;
    if (in_type == REQ_LIT) begin
      head_val = LEN_W'(1);
      head_cnt = CNT_W'(1);
    end else if (in_type == REQ_RUN) begin
      head_val = LEN_W'(1);
      head_cnt = CNT_W'(ESC_FLAGS);
    end else if (in_type == REQ_END) begin
      head_cnt = CNT_W'(ESC_FLAGS);
    end else if (in_type == REQ_MATCH) begin
      // zero flag, then gamma: nbits-1 zeros and the length in nbits bits
      head_val = in_len;
      head_cnt = CNT_W'({nbits, 1'b0});
    end
  end

  assign head_seg = SEG_W'(head_val) << (CNT_W'(SEG_W) - head_cnt);

  // offset classes, tested from the widest down
  assign cls3  = (v0 >= OFS_W'(lim3));
  assign cls2  = (v0 >= OFS_W'(lim2));
  assign cls1  = (v0 >= OFS_W'(lim1));
  assign zeros = {1'b0, (len_q > LEN_W'(2))} + {1'b0, (len_q > LEN_W'(1))};

  always_comb begin
    priority if (cls3) begin
      lim_sel = OFS_W'(lim3);
    end else if (cls2) begin
      lim_sel = OFS_W'(lim2);
    end else if (cls1) begin
      lim_sel = OFS_W'(lim1);
    end else begin
      lim_sel = '0;
    end
  end

  assign sub = v0 - lim_sel;

  always_comb begin
    priority if (cls3) begin
      offs_val = OFW'({1'b1, sub[8 +: HI_W]});
      offs_cnt = CNT_W'(1 + HI_W);
    end else if (cls2) begin
      offs_val = OFW'(1);
      offs_cnt = CNT_W'(1) + CNT_W'(len_q > LEN_W'(2));
    end else if (cls1) begin
      offs_val = OFW'({1'b1, sub[OFFSET_BITS2-1:0]});
      offs_cnt = CNT_W'(zeros) + CNT_W'(1 + OFFSET_BITS2);
    end else begin
      offs_val = OFW'(sub[OFFSET_BITS1-1:0]);
      offs_cnt = CNT_W'(zeros) + CNT_W'(1 + OFFSET_BITS1);
    end
  end

  assign offs_seg = SEG_W'(offs_val) << (CNT_W'(SEG_W) - offs_cnt);

  // drain up to the end of the flag byte in one step
  assign room      = 4'd8 - {1'b0, fill};
  assign k         = (cnt < CNT_W'(room)) ? cnt[3:0] : room;
  assign fsum      = {1'b0, fill} + k;
  assign top       = seg[SEG_W-1 -: BYTE_W];
  assign ins       = (top & ~(8'hFF >> k)) >> fill;
  assign fnew      = (fopen ? fbyte : 8'h00) | ins;
  assign faddr_eff = fopen ? faddr : wp;

  assign sts.out_free   = !out_valid || out_ready;
  assign sts.drain_emit = (fsum == 4'd8);
  assign sts.drain_done = (cnt <= CNT_W'(room));
  assign sts.offs_byte  = cls3 || cls2;

  assign emit = (cmd.drain && sts.drain_emit) || cmd.put_byte || cmd.flush;

  always_comb begin
    priority if (cmd.put_byte) begin
      addr_sel = wp;
      data_sel = dbyte;
      last_sel = 1'b0;
    end else if (cmd.flush) begin
      addr_sel = faddr;
      data_sel = fbyte;
      last_sel = 1'b1;
    end else begin
      addr_sel = faddr_eff;
      data_sel = fnew;
      last_sel = cmd.end_tok && sts.drain_done;
    end
  end

  assign addr_ext = AXW'(addr_sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      lim1      <= LIM1_RST;
      lim2      <= LIM2_RST;
      lim3      <= LIM3_RST;
      wp        <= '0;
      fill      <= '0;
      fopen     <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_LIM1: lim1 <= cfg_data[LIM1_W-1:0];
          CFG_LIM2: lim2 <= cfg_data[LIM2_W-1:0];
          CFG_LIM3: lim3 <= cfg_data[LIM3_W-1:0];
          default:  ;
        endcase
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.put_byte || (cmd.drain && !fopen)) begin
        wp <= wp + ADDR_BITS'(1);
      end

      if (cmd.drain) begin
        if (sts.drain_emit) begin
          fopen <= 1'b0;
          fill  <= '0;
        end else begin
          fopen <= 1'b1;
          fill  <= fsum[2:0];
        end
      end else if (cmd.flush) begin
        fopen <= 1'b0;
        fill  <= '0;
      end

      if (cmd.take) begin
        cnt <= head_cnt;
      end else if (cmd.load_offs) begin
        cnt <= offs_cnt;
      end else if (cmd.drain) begin
        cnt <= cnt - CNT_W'(k);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (emit) begin
      out_addr <= addr_ext[WADDR_W-1:0];
      out_data <= data_sel;
      out_last <= last_sel;
    end
    if (cmd.drain) begin
      faddr <= faddr_eff;
      fbyte <= fnew;
    end
    if (cmd.take) begin
      seg   <= head_seg;
      len_q <= in_len;
      v0    <= in_off - OFS_W'(1);
      dbyte <= (in_type == REQ_RUN) ? run_raw[BYTE_W-1:0] : in_byte;
    end else if (cmd.load_offs) begin
      seg <= offs_seg;
      if (sts.offs_byte) begin
        dbyte <= sub[BYTE_W-1:0];
      end
    end else if (cmd.drain) begin
      seg <= seg << k;
    end
  end

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || out_ready))
    else $error("write issued over an untaken result");

  a_piece_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.drain && sts.drain_done && !cmd.load_offs && !cmd.take) |=> (cnt == '0))
    else $error("flag piece not empty after final drain");

  a_flush_open: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |-> fopen)
    else $error("flush without an open flag byte");

endmodule

FILE: bench/lztbp_write_check.sv
// predicts the byte writes of the lz token bit packer and checks the write stream against them
module lztbp_write_check
  import lztbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [TYPE_W-1:0]     s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending_writes,
  output int                    requests_seen,
  output int                    writes_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ABITS      = ADDR_BITS_DEF;
  localparam int MAX_WRITES = 8;

  typedef struct {
    logic [WADDR_W-1:0] addr;
    logic [BYTE_W-1:0]  data;
    logic               last;
  } byte_write_t;

  byte_write_t expected_writes[$];

  // encoder state as the block should hold it
  logic [ABITS-1:0]  wr_ptr;
  logic [ABITS-1:0]  flag_addr;
  logic [7:0]        flag_bits;
  logic [7:0]        flag_mask;
  logic              flag_open;
  logic [LIM1_W-1:0] lim1;
  logic [LIM2_W-1:0] lim2;
  logic [LIM3_W-1:0] lim3;

  int token_writes;
  int fails;
  int n_req;
  int n_wr;

  task automatic report_mismatch(string what);
    if (fails < 100) $display("%0t ns  write mismatch: %s", $time, what);
    fails++;
  endtask

  function automatic void add_write(logic [ABITS-1:0] addr, logic [7:0] data);
    byte_write_t w;
    if (token_writes >= MAX_WRITES) return;
    w.addr = WADDR_W'(addr);
    w.data = data;
    w.last = 1'b0;
    expected_writes.push_back(w);
    token_writes++;
  endfunction

  function automatic void put_data_byte(logic [7:0] value);
    add_write(wr_ptr, value);
    wr_ptr = wr_ptr + ABITS'(1);
  endfunction

  // flag bits go msb first; the flag byte slot is taken when its first bit is needed
  function automatic void put_flag(bit value);
    if (flag_mask == 8'd0) begin
      flag_mask = 8'h80;
      flag_addr = wr_ptr;
      wr_ptr    = wr_ptr + ABITS'(1);
      flag_bits = 8'd0;
      flag_open = 1'b1;
    end
    if (value) flag_bits = flag_bits | flag_mask;
    flag_mask = flag_mask >> 1;
    if (flag_mask == 8'd0) begin
      add_write(flag_addr, flag_bits);
      flag_open = 1'b0;
    end
  endfunction

  function automatic void put_bits(int unsigned value, int count);
    for (int i = count - 1; i >= 0; i--) put_flag(((value >> i) & 1) != 0);
  endfunction

  function automatic void put_gamma_len(int unsigned value);
    int unsigned i;
    i = 2;
    while (i <= value) begin
      put_flag(1'b0);
      i = i << 1;
    end
    i = i >> 1;
    while (i > 0) begin
      put_flag((value & i) != 0);
      i = i >> 1;
    end
  endfunction

  // classes are tried from the widest down; prefix zeros depend on the length
  function automatic void put_offset_code(int unsigned ofs, int unsigned len);
    int unsigned v;
    v = (ofs - 1) & 32'h1ffff;
    if (v >= lim3) begin
      put_flag(1'b1);
      v = v - lim3;
      put_bits(v >> 8, OFFSET_BITS4_DEF - 8);
      put_data_byte(8'(v));
    end else if (v >= lim2) begin
      if (len > 2) put_flag(1'b0);
      put_flag(1'b1);
      put_data_byte(8'(v - lim2));
    end else if (v >= lim1) begin
      if (len > 2) put_flag(1'b0);
      if (len > 1) put_flag(1'b0);
      put_flag(1'b1);
      put_bits(v - lim1, OFFSET_BITS2_DEF);
    end else begin
      if (len > 2) put_flag(1'b0);
      if (len > 1) put_flag(1'b0);
      put_flag(1'b0);
      put_bits(v, OFFSET_BITS1_DEF);
    end
  endfunction

  function automatic void encode_token(logic [TYPE_W-1:0] kind, logic [BYTE_W-1:0] value,
                                       logic [LEN_W-1:0] len_in, logic [OFS_W-1:0] ofs_in);
    int unsigned len;
    len = 32'(len_in);
    token_writes = 0;
    case (kind)
      REQ_RAW: begin
        put_data_byte(value);
      end
      REQ_LIT: begin
        put_flag(1'b1);
        put_data_byte(value);
      end
      REQ_RUN: begin
        put_flag(1'b0);
        put_bits(0, ESCAPE_ZEROS);
        put_flag(1'b1);
        put_data_byte(8'(len - RUN_BIAS));
      end
      REQ_MATCH: begin
        put_flag(1'b0);
        put_gamma_len(len);
        put_offset_code(32'(ofs_in), len);
      end
      REQ_END: begin
        put_flag(1'b0);
        put_bits(0, ESCAPE_ZEROS);
        put_flag(1'b0);
        if (flag_open) begin
          add_write(flag_addr, flag_bits);
          flag_open = 1'b0;
          flag_mask = 8'd0;
        end
        if (token_writes > 0) expected_writes[expected_writes.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    byte_write_t got;
    byte_write_t want;
    if (rst) begin
      wr_ptr    = '0;
      flag_addr = '0;
      flag_bits = 8'd0;
      flag_mask = 8'd0;
      flag_open = 1'b0;
      lim1      = LIM1_RST;
      lim2      = LIM2_RST;
      lim3      = LIM3_RST;
      expected_writes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LIM1: lim1 = cfg_data[LIM1_W-1:0];
          CFG_LIM2: lim2 = cfg_data[LIM2_W-1:0];
          CFG_LIM3: lim3 = cfg_data[LIM3_W-1:0];
          default: ;
        endcase
      end
      // writes out now belong to requests taken at earlier edges
      if (m_tvalid && m_tready) begin
        got.addr = m_tdata[WADDR_W-1:0];
        got.data = m_tdata[WADDR_W +: BYTE_W];
        got.last = m_tlast;
        n_wr++;
        if (expected_writes.size() == 0) begin
          report_mismatch($sformatf("write %h <- %h with nothing expected", got.addr, got.data));
        end else begin
          want = expected_writes.pop_front();
          if (got.addr !== want.addr)
            report_mismatch($sformatf("address %h, want %h", got.addr, want.addr));
          if (got.data !== want.data)
            report_mismatch($sformatf("data %h at %h, want %h", got.data, want.addr, want.data));
          if (got.last !== want.last)
            report_mismatch($sformatf("last %b at %h, want %b", got.last, want.addr, want.last));
        end
      end
      if (s_tvalid && s_tready) begin
        n_req++;
        encode_token(s_tuser, s_tdata[BYTE_W-1:0], s_tdata[BYTE_W +: LEN_W],
                     s_tdata[BYTE_W+LEN_W +: OFS_W]);
      end
    end
    fail_count     <= fails;
    pending_writes <= expected_writes.size();
    requests_seen  <= n_req;
    writes_seen    <= n_wr;
  end

endmodule

FILE: bench/tb.sv
// top of the lz token bit packer bench: clock, reset, token stimulus, stalls and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lztbp_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int LIMIT_CYCLES  = 800000;
  localparam int SETTLE_CYCLES = 32;
  localparam int PHASE_ITEMS   = 65;
  localparam int LONG_ITEMS    = 20;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // byte_value, token_length, match_offset, zero pad
  logic [TYPE_W-1:0]     s_tuser = '0;   // req_type
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // write_address, write_data
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending_writes;
  int requests_seen;
  int writes_seen;

  // stall knobs, percent per cycle
  int idle_pct = 0;
  int stall_pct = 0;
  // long output hold-off asked by the stimulus, counted down by the receiver
  int holdoff_req = 0;
  int holdoff_left = 0;

  // limits as last written, used to aim offsets at the class edges
  int cur_lim1 = int'(LIM1_RST);
  int cur_lim2 = int'(LIM2_RST);
  int cur_lim3 = int'(LIM3_RST);

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  lz_token_bit_packer_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lztbp_write_check write_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending_writes (pending_writes),
    .requests_seen  (requests_seen),
    .writes_seen    (writes_seen)
  );

  // write receiver: random back-pressure, or a solid hold-off when one is asked
  always @(posedge clk) begin
    if (holdoff_req > 0) begin
      holdoff_left = holdoff_req;
      holdoff_req  = 0;
    end
    if (holdoff_left > 0) begin
      m_tready <= 1'b0;
      holdoff_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // one request; valid stays high from one request to the next unless an idle cycle falls
  task automatic send_request(logic [TYPE_W-1:0] kind, logic [BYTE_W-1:0] value,
                              logic [LEN_W-1:0] len, logic [OFS_W-1:0] ofs);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(IN_DATA_W - BYTE_W - LEN_W - OFS_W){1'b0}}, ofs, len, value};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // wait until every predicted write is out and the sequencer has gone quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_writes != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // limits change only with the block idle
  task automatic set_limits(int l1, int l2, int l3);
    settle();
    cfg_write(CFG_LIM1, l1);
    cfg_write(CFG_LIM2, l2);
    cfg_write(CFG_LIM3, l3);
    cfg_valid <= 1'b0;
    cur_lim1 = l1;
    cur_lim2 = l2;
    cur_lim3 = l3;
  endtask

  // half the offsets sit on a class edge, the rest are small, below lim3 plus 600 or anywhere in the 17-bit field
  function automatic logic [OFS_W-1:0] pick_offset();
    int v;
    case ($urandom_range(5))
      0: v = $urandom_range(3);
      1: v = cur_lim1 + $urandom_range(2) - 1;
      2: v = cur_lim2 + $urandom_range(2) - 1;
      3: v = cur_lim3 + $urandom_range(2) - 1;
      4: v = $urandom_range(cur_lim3 + 600);
      default: v = $urandom;
    endcase
    return OFS_W'(v + 1);
  endfunction

  task automatic send_random();
    int pick;
    logic [TYPE_W-1:0] kind;
    logic [BYTE_W-1:0] value;
    logic [LEN_W-1:0]  len;
    pick  = $urandom_range(99);
    value = BYTE_W'($urandom);
    len   = LEN_W'($urandom);
    if (pick < 6) kind = TYPE_W'($urandom_range(7, REQ_END + 1));
    else if (pick < 16) kind = REQ_END;
    else if (pick < 30) kind = REQ_RAW;
    else if (pick < 50) kind = REQ_LIT;
    else if (pick < 62) kind = REQ_RUN;
    else kind = REQ_MATCH;
    // short lengths hit the gamma and prefix corner cases
    case ($urandom_range(3))
      0: len = LEN_W'($urandom_range(3));
      1: len = LEN_W'($urandom_range(282, 1));
      default: ;
    endcase
    send_request(kind, value, len, pick_offset());
  endtask

  task automatic random_phase(int idle, int stall, bit with_holdoff);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      // the sender keeps offering during the hold-off so the block backs up
      if (with_holdoff && i == 20) holdoff_req = 400;
      send_random();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed tokens at the reset limits
    send_request(REQ_RAW, 8'h00, 9'd1, 17'd1);
    send_request(REQ_RAW, 8'hff, 9'd511, 17'h1ffff);
    send_request(REQ_LIT, 8'h5a, 9'd0, 17'd0);
    send_request(REQ_LIT, 8'hff, 9'd3, 17'd5);
    // run header bias: zero, wrap below zero, largest length, zero length
    send_request(REQ_RUN, 8'h00, 9'd27, 17'd1);
    send_request(REQ_RUN, 8'h00, 9'd26, 17'd1);
    send_request(REQ_RUN, 8'h00, 9'd282, 17'd1);
    send_request(REQ_RUN, 8'h00, 9'd0, 17'd1);
    // matches in every offset class, with lengths across the prefix rules
    send_request(REQ_MATCH, 8'h00, 9'd1, 17'd1);
    send_request(REQ_MATCH, 8'h00, 9'd2, 17'd2);
    send_request(REQ_MATCH, 8'h00, 9'd3, 17'd3);
    send_request(REQ_MATCH, 8'h00, 9'd0, 17'd19);
    send_request(REQ_MATCH, 8'h00, 9'd511, 17'd275);
    // zero offset wraps, top offset overflows the high field
    send_request(REQ_MATCH, 8'h00, 9'd282, 17'd0);
    send_request(REQ_MATCH, 8'h00, 9'd256, 17'h1ffff);
    send_request(REQ_MATCH, 8'h00, 9'd2, 17'd18);
    // unused kinds must leave no trace
    for (int k = REQ_END + 1; k < 8; k++) send_request(TYPE_W'(k), 8'ha5, 9'd5, 17'd9);
    send_request(REQ_END, 8'h00, 9'd0, 17'd0);
    // the stream carries on after an end mark
    send_request(REQ_RAW, 8'h11, 9'd0, 17'd0);
    send_request(REQ_LIT, 8'h22, 9'd0, 17'd0);
    send_request(REQ_END, 8'h00, 9'd0, 17'd0);
    send_request(REQ_END, 8'h00, 9'd0, 17'd0);
    send_request(REQ_MATCH, 8'h00, 9'd511, 17'd65536 & 17'h1ffff);

    // a short run of long class-3 matches, several flag bytes each
    for (int i = 0; i < LONG_ITEMS; i++)
      send_request(REQ_MATCH, BYTE_W'($urandom), LEN_W'($urandom_range(511, 256)),
                   OFS_W'($urandom_range(131071, 274) + 1));

    // random phases, each with its own limits and stall pattern
    set_limits(1, 2, 3);
    random_phase(0, 0, 1'b1);
    set_limits(256, 4096, 8192);
    random_phase(64, 0, 1'b0);
    set_limits($urandom_range(256, 1), $urandom_range(4096, 2), $urandom_range(8192, 3));
    random_phase(0, 64, 1'b0);
    set_limits(int'(LIM1_RST), int'(LIM2_RST), int'(LIM3_RST));
    random_phase(34, 34, 1'b0);

    // drain, bounded, then a quiet tail to catch stray writes
    s_tvalid <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < 50000 && pending_writes != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d token requests and %0d byte writes, all kinds incl. unused ones",
             requests_seen, writes_seen);
    $display("four stall patterns, four limit settings, long matches and a long hold-off");
    if (fail_count == 0 && pending_writes == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(2 * CLK_HALF * LIMIT_CYCLES);
    $display("tb failed");
    $finish;
  end

endmodule

FILE: lz_token_bit_packer_top.f
src/lztbp_pkg.sv
src/lztbp_ctrl.sv
src/lztbp_datapath.sv
src/lz_token_bit_packer_top.sv
bench/lztbp_write_check.sv
bench/tb.sv
